/* src/rhg_pkg.sv */
// ----------------------------------------------------------------------------
// rhg_pkg
// Types and constants shared by the radial hue gradient pixel generator.
// ----------------------------------------------------------------------------
package rhg_pkg;

  // Register index codes on the configuration port
  localparam logic [1:0] CFG_IMAGE_SIZE = 2'd0;
  localparam logic [1:0] CFG_SATURATION = 2'd1;
  localparam logic [1:0] CFG_BRIGHTNESS = 2'd2;

  localparam int SIZE_W = 13;   // image_size register
  localparam int LVL_W  = 9;    // saturation / brightness registers
  localparam int DEN_W  = 27;   // 2*(size-1)^2 for any 13-bit size
  localparam int CHR_W  = 17;   // s*v, up to 1.0 in 2^-16 units

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_out_t;

endpackage

/* src/radial_hue_gradient_pixel.sv */
// ----------------------------------------------------------------------------
// radial_hue_gradient_pixel
// Pixel coordinate in, RGB color of a square radial hue gradient out.
// ----------------------------------------------------------------------------
// Fully pipelined: one pixel is accepted every clock while the output is not
// stalled. Each pixel passes through 3*FRAC_BITS+7 register stages (55 at the
// default): the restoring divider (2*FRAC_BITS stages, one quotient bit each),
// the digit-by-digit square root (FRAC_BITS stages, one root bit each) and
// seven stages of offset, hue and color math. The whole pipeline moves on one
// enable, so a stalled output holds every stage. Configuration is to be written
// through cfg_* only while no pixel is in flight; the user must keep to this,
// the block itself does not enforce it.
module radial_hue_gradient_pixel #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rhg_pkg::pix_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rhg_pkg::pix_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import rhg_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int AW    = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int NW    = 2 * AW + 1;
  localparam int QW    = 2 * FRAC_BITS;
  localparam int NDIV  = QW;
  localparam int NFL   = NDIV + FRAC_BITS;
  localparam int SRW   = FRAC_BITS + 2;
  localparam int RW    = FRAC_BITS + 1;
  localparam int TOTW  = FRAC_BITS + 18;
  localparam int HIW   = TOTW + 8 - (16 + FRAC_BITS);
  localparam int LAT   = 3 + NDIV + FRAC_BITS + 4;
  localparam int P1IDX = 3 + NFL;
  localparam logic [RW-1:0] ONE = RW'(1) << FRAC_BITS;

  // configuration registers
  logic [SIZE_W-1:0] size_r;
  logic [LVL_W-1:0]  sat_r, bri_r;
  logic [DEN_W-1:0]  den_r;
  logic [CHR_W-1:0]  c_r, m_r;
  logic              small_r;

  // pipeline
  logic [LAT-1:0]    vld_r;
  logic              adv;
  logic [AW-1:0]     ax_r, ay_r;
  logic [2*AW-1:0]   sqx_r, sqy_r;
  logic [DEN_W-1:0]  dv_rem_r [0:NDIV];
  logic [QW-1:0]     dv_q_r   [0:NDIV];
  logic [DEN_W-1:0]  dv_rem_nxt [1:NDIV];
  logic [QW-1:0]     dv_q_nxt   [1:NDIV];
  logic [SRW-1:0]    sq_rem_r  [1:FRAC_BITS];
  logic [FRAC_BITS-1:0] sq_root_r [1:FRAC_BITS];
  logic [QW-1:0]     sq_src_r  [1:FRAC_BITS];
  logic [SRW-1:0]    sq_rem_nxt  [1:FRAC_BITS];
  logic [FRAC_BITS-1:0] sq_root_nxt [1:FRAC_BITS];
  logic [QW-1:0]     sq_src_nxt  [1:FRAC_BITS];
  logic              fz_r [0:NFL];
  logic              fs_r [0:NFL];
  logic [2:0]        p1_sector_r, p2_sector_r;
  logic [RW-1:0]     p1_t_r;
  logic [TOTW-1:0]   p2_x_r;
  logic [TOTW-1:0]   p3_r_r, p3_g_r, p3_b_r;
  logic [7:0]        o_r_r, o_g_r, o_b_r;

  // config write transaction
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(256);
      sat_r  <= LVL_W'(256);
      bri_r  <= LVL_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_SIZE: size_r <= cfg_data;
        CFG_SATURATION: sat_r  <= cfg_data[LVL_W-1:0];
        CFG_BRIGHTNESS: bri_r  <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // values derived from configuration
  logic [SIZE_W-1:0] span;
  logic [LVL_W-1:0]  s_sat, v_sat;
  logic [CHR_W-1:0]  c_val;
  assign span  = size_r - SIZE_W'(1);
  assign s_sat = (sat_r > LVL_W'(256)) ? LVL_W'(256) : sat_r;
  assign v_sat = (bri_r > LVL_W'(256)) ? LVL_W'(256) : bri_r;
  assign c_val = CHR_W'(s_sat * v_sat);

  always_ff @(posedge clk) begin
    den_r   <= DEN_W'({span, 1'b0} * span);
    c_r     <= c_val;
    m_r     <= CHR_W'({v_sat, 8'd0}) - c_val;
    small_r <= (size_r <= SIZE_W'(1));
  end

  // handshake: the whole pipeline moves together
  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: doubled offsets as magnitudes
  logic [AW-1:0] x2, y2, spx;
  assign x2  = AW'({CW'(in_data.col), 1'b0});
  assign y2  = AW'({CW'(in_data.row), 1'b0});
  assign spx = AW'(span);

  // stage 3 sums
  logic [NW-1:0] num;
  assign num = NW'(sqx_r) + NW'(sqy_r);

  // divider: one quotient bit per stage
  always_comb begin
    logic [DEN_W:0] rsh;
    for (int k = 1; k <= NDIV; k++) begin
      rsh = {dv_rem_r[k-1], 1'b0};
      if (rsh >= {1'b0, den_r}) begin
        dv_rem_nxt[k] = DEN_W'(rsh - {1'b0, den_r});
        dv_q_nxt[k]   = {dv_q_r[k-1][QW-2:0], 1'b1};
      end else begin
        dv_rem_nxt[k] = rsh[DEN_W-1:0];
        dv_q_nxt[k]   = {dv_q_r[k-1][QW-2:0], 1'b0};
      end
    end
  end

  // square root: one root bit per stage
  always_comb begin
    logic [SRW-1:0]       rin;
    logic [FRAC_BITS-1:0] oin;
    logic [QW-1:0]        sin;
    logic [SRW+1:0]       rsh, trial;
    for (int j = 1; j <= FRAC_BITS; j++) begin
      rin = (j == 1) ? '0 : sq_rem_r[j-1];
      oin = (j == 1) ? '0 : sq_root_r[j-1];
      sin = (j == 1) ? dv_q_r[NDIV] : sq_src_r[j-1];
      rsh   = {rin, sin[QW-1:QW-2]};
      trial = (SRW+2)'({oin, 2'b01});
      if (rsh >= trial) begin
        sq_rem_nxt[j]  = SRW'(rsh - trial);
        sq_root_nxt[j] = {oin[FRAC_BITS-2:0], 1'b1};
      end else begin
        sq_rem_nxt[j]  = rsh[SRW-1:0];
        sq_root_nxt[j] = {oin[FRAC_BITS-2:0], 1'b0};
      end
      sq_src_nxt[j] = {sin[QW-3:0], 2'b00};
    end
  end

  // hue: sector and ramp from the ratio
  logic [RW-1:0]          ratio;
  logic [FRAC_BITS+2:0]   h6;
  logic [2:0]             hint, sector;
  logic [FRAC_BITS-1:0]   frac;
  assign ratio  = fz_r[NFL] ? '0 : (fs_r[NFL] ? ONE : RW'(sq_root_r[FRAC_BITS]));
  assign h6     = (FRAC_BITS+3)'({ratio, 2'b00}) + (FRAC_BITS+3)'({ratio, 1'b0});
  assign hint   = h6[FRAC_BITS+2:FRAC_BITS];
  assign sector = (hint == 3'd6) ? 3'd0 : hint;
  assign frac   = h6[FRAC_BITS-1:0];

  // component placement by sector
  logic [TOTW-1:0] cc, mm, tr, tg, tb;
  assign cc = TOTW'(c_r) << FRAC_BITS;
  assign mm = TOTW'(m_r) << FRAC_BITS;

  always_comb begin
    case (p2_sector_r)
      3'd0: begin tr = cc;     tg = p2_x_r; tb = '0;     end
      3'd1: begin tr = p2_x_r; tg = cc;     tb = '0;     end
      3'd2: begin tr = '0;     tg = cc;     tb = p2_x_r; end
      3'd3: begin tr = '0;     tg = p2_x_r; tb = cc;     end
      3'd4: begin tr = p2_x_r; tg = '0;     tb = cc;     end
      default: begin tr = cc;  tg = '0;     tb = p2_x_r; end
    endcase
  end

  // scale to a byte: floor(total*255 / 2^(16+F)), clamped
  function automatic logic [7:0] to_byte(input logic [TOTW-1:0] tot);
    logic [TOTW+7:0] p;
    logic [HIW-1:0]  hi;
    p  = {tot, 8'd0} - (TOTW+8)'(tot);
    hi = p[TOTW+7:16+FRAC_BITS];
    to_byte = (hi > HIW'(255)) ? 8'hFF : hi[7:0];
  endfunction

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r  <= (x2 >= spx) ? x2 - spx : spx - x2;
      ay_r  <= (y2 >= spx) ? y2 - spx : spx - y2;
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
      dv_rem_r[0] <= num[DEN_W-1:0];
      dv_q_r[0]   <= '0;
      fz_r[0]     <= small_r;
      fs_r[0]     <= (num >= NW'(den_r));
      for (int k = 1; k <= NDIV; k++) begin
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_q_r[k]   <= dv_q_nxt[k];
      end
      for (int j = 1; j <= FRAC_BITS; j++) begin
        sq_rem_r[j]  <= sq_rem_nxt[j];
        sq_root_r[j] <= sq_root_nxt[j];
        sq_src_r[j]  <= sq_src_nxt[j];
      end
      for (int f = 1; f <= NFL; f++) begin
        fz_r[f] <= fz_r[f-1];
        fs_r[f] <= fs_r[f-1];
      end
      p1_sector_r <= sector;
      p1_t_r      <= sector[0] ? ONE - RW'(frac) : RW'(frac);
      p2_sector_r <= p1_sector_r;
      p2_x_r      <= TOTW'(c_r * p1_t_r);
      p3_r_r      <= tr + mm;
      p3_g_r      <= tg + mm;
      p3_b_r      <= tb + mm;
      o_r_r       <= to_byte(p3_r_r);
      o_g_r       <= to_byte(p3_g_r);
      o_b_r       <= to_byte(p3_b_r);
    end
  end

  assign out_data.red   = o_r_r;
  assign out_data.green = o_g_r;
  assign out_data.blue  = o_b_r;

  // checks
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[2+NDIV] && !fz_r[NDIV] && !fs_r[NDIV]) |-> (dv_rem_r[NDIV] < den_r))
    else $error("divider remainder not below divisor");

  a_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P1IDX] |-> (p1_t_r <= ONE))
    else $error("hue ramp above one");

  a_center: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[P1IDX-1] && fz_r[NFL]) |=> (p1_sector_r == 3'd0 && p1_t_r == '0))
    else $error("single-pixel image not mapped to hue zero");

endmodule

/* sim/radial_hue_gradient_pixel_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_hue_gradient_pixel_tb
// Drives pixel coordinates through the radial hue gradient generator under
// several image size / saturation / brightness settings, predicts each RGB
// result in exact fixed point and checks every result in order.
// ----------------------------------------------------------------------------
module radial_hue_gradient_pixel_tb;
  import rhg_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 3 * FRAC + 7;
  localparam longint CYCLE_LIMIT = 400000;
  // Register index with no register behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  pix_in_t in_data;
  logic out_valid;
  logic out_ready;
  pix_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;

  int errors;
  longint cycles;

  // Predictor copy of the configuration
  logic [12:0] size_q;
  logic [8:0] sat_q;
  logic [8:0] bri_q;

  radial_hue_gradient_pixel DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // floor(sqrt(v)) bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] scale_byte(input longint unsigned total);
    longint unsigned v;
    v = (total * 255) >> (16 + FRAC);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Expected color of one pixel under the current settings
  function automatic pix_out_t pixel_color(input pix_in_t p);
    longint signed span, dx, dy;
    longint unsigned num, den, q, ratio, h6, sector, f, t, s, v, c, m, cc, xx, mm;
    longint unsigned r1, g1, b1;
    pix_out_t o;
    ratio = 0;
    if (size_q > 1) begin
      span = longint'(size_q) - 1;
      dx = 2 * longint'(p.col) - span;
      dy = 2 * longint'(p.row) - span;
      num = dx * dx + dy * dy;
      den = 2 * span * span;
      if (num >= den) ratio = 64'd1 << FRAC;
      else begin
        // num/den < 1 here, so the long division fits
        q = (num << (2 * FRAC)) / den;
        ratio = int_sqrt(q);
      end
    end
    h6 = ratio * 6;
    sector = (h6 >> FRAC) % 6;
    f = h6 & ((64'd1 << FRAC) - 1);
    t = sector[0] ? (64'd1 << FRAC) - f : f;
    s = (sat_q > 256) ? 256 : sat_q;
    v = (bri_q > 256) ? 256 : bri_q;
    c = s * v;
    m = (v << 8) - c;
    cc = c << FRAC;
    xx = c * t;
    mm = m << FRAC;
    case (sector)
      0: begin r1 = cc; g1 = xx; b1 = 0; end
      1: begin r1 = xx; g1 = cc; b1 = 0; end
      2: begin r1 = 0; g1 = cc; b1 = xx; end
      3: begin r1 = 0; g1 = xx; b1 = cc; end
      4: begin r1 = xx; g1 = 0; b1 = cc; end
      default: begin r1 = cc; g1 = 0; b1 = xx; end
    endcase
    o.red = scale_byte(r1 + mm);
    o.green = scale_byte(g1 + mm);
    o.blue = scale_byte(b1 + mm);
    return o;
  endfunction

  // Holds expected colors in acceptance order
  class color_scoreboard;
    pix_out_t pending[$];

    function void note_pixel(input pix_out_t want);
      pending.push_back(want);
    endfunction

    task check_color(input pix_out_t got);
      pix_out_t want;
      if (pending.size() == 0) begin
        report("unexpected result, red", got.red, 8'd0);
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red) report("red", got.red, want.red);
      if (got.green !== want.green) report("green", got.green, want.green);
      if (got.blue !== want.blue) report("blue", got.blue, want.blue);
    endtask
  endclass

  color_scoreboard board;

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("radial_hue_gradient_pixel verification failed");
      $finish;
    end
  end

  // Monitor: predict on input transactions, check on output transactions
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_pixel(pixel_color(in_data));
    if (rst_n && out_valid && out_ready) board.check_color(out_data);
  end

  // Receiver stall pattern: alternating runs of ready / stall, some long free runs
  initial begin
    int run;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 40);
      repeat (run) @(posedge clk) out_ready <= 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        run = $urandom_range(1, 6);
        repeat (run) @(posedge clk) out_ready <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IMAGE_SIZE: size_q = val;
      CFG_SATURATION: sat_q = val[8:0];
      CFG_BRIGHTNESS: bri_q = val[8:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [12:0] sz, input logic [8:0] s, input logic [8:0] b);
    write_reg(CFG_IMAGE_SIZE, sz);
    write_reg(CFG_SATURATION, {4'd0, s});
    write_reg(CFG_BRIGHTNESS, {4'd0, b});
  endtask

  // Present one pixel; valid stays high across back-to-back transactions
  task automatic send_pixel(input logic [11:0] c, input logic [11:0] r, input bit keep);
    in_valid <= 1'b1;
    in_data <= '{col: c, row: r};
    do @(posedge clk); while (!in_ready);
    if (!keep) in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Random pixels in bursts; mostly on the image, some off it
  task automatic random_phase(input int count);
    int burst, gap, i;
    logic [11:0] c, r;
    logic [12:0] lim;
    i = 0;
    lim = (size_q == 0) ? 13'd1 : size_q;
    while (i < count) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && i < count) begin
        if ($urandom_range(0, 9) == 0) begin
          c = 12'($urandom); r = 12'($urandom);
        end else begin
          c = (lim > 4096) ? 12'($urandom) : 12'($urandom_range(0, lim - 1));
          r = (lim > 4096) ? 12'($urandom) : 12'($urandom_range(0, lim - 1));
        end
        send_pixel(c, r, burst > 1 && i < count - 1);
        burst--;
        i++;
      end
      @(posedge clk);
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IMAGE_SIZE;
    cfg_data = '0;
    size_q = 13'd256;
    sat_q = 9'd256;
    bri_q = 9'd256;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, corners, center, edges, off image, extremes
    send_pixel(12'd0, 12'd0, 1'b1);
    send_pixel(12'd255, 12'd255, 1'b1);
    send_pixel(12'd128, 12'd128, 1'b1);
    send_pixel(12'd127, 12'd128, 1'b1);
    send_pixel(12'd0, 12'd128, 1'b1);
    send_pixel(12'd4095, 12'd4095, 1'b1);
    send_pixel(12'd300, 12'd5, 1'b1);
    send_pixel(12'hAAA, 12'h555, 1'b1);
    send_pixel(12'h555, 12'hAAA, 1'b0);
    wait_drain();
    apply_settings(13'd1, 9'd256, 9'd256);   // single-pixel image
    send_pixel(12'd0, 12'd0, 1'b1);
    send_pixel(12'd4095, 12'd7, 1'b0);
    wait_drain();
    apply_settings(13'd0, 9'd511, 9'd300);   // size zero, levels above 1.0
    send_pixel(12'd3, 12'd9, 1'b0);
    wait_drain();
    apply_settings(13'd8191, 9'd0, 9'd0);    // beyond 4096, black
    send_pixel(12'd4095, 12'd0, 1'b1);
    send_pixel(12'd2048, 12'd2048, 1'b0);
    wait_drain();
    apply_settings(13'd4096, 9'd128, 9'd200);
    send_pixel(12'd0, 12'd4095, 1'b1);
    send_pixel(12'd2047, 12'd2048, 1'b1);
    send_pixel(12'd1000, 12'd3000, 1'b0);
    wait_drain();
    write_reg(CFG_SPARE, 13'h1FFF);          // unused index, ignored

    // Random phases through several settings
    apply_settings(13'd256, 9'd256, 9'd256);
    random_phase(250);
    wait_drain();
    apply_settings(13'd2, 9'd256, 9'd256);
    random_phase(100);
    wait_drain();
    apply_settings(13'($urandom_range(3, 64)), 9'($urandom_range(0, 256)),
                   9'($urandom_range(0, 256)));
    random_phase(250);
    wait_drain();
    apply_settings(13'd4096, 9'($urandom), 9'($urandom));
    random_phase(200);
    wait_drain();
    apply_settings(13'($urandom), 9'($urandom), 9'($urandom));
    random_phase(150);
    wait_drain();
    apply_settings(13'($urandom_range(65, 1000)), 9'd256, 9'd256);
    random_phase(200);
    wait_drain();

    if (errors == 0 && board.pending.size() == 0) begin
      $display("radial_hue_gradient_pixel verification clean");
    end else begin
      $display("radial_hue_gradient_pixel verification failed");
    end
    $finish;
  end

endmodule
